[rtl/meu_pkg.sv]
// Shared types, codes and helpers for the execute unit.
package meu_pkg;

    localparam int unsigned DATA_BYTES_DEF = 65536;
    localparam logic [31:0] DATA_BASE_DEF  = 32'h1001_0000;
    localparam int unsigned QUEUE_DEPTH    = 2;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DSIZE  = 2'd2;

    localparam logic [1:0] CMD_EXEC  = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    localparam logic [5:0] OPC_SPECIAL = 6'h00;
    localparam logic [5:0] OPC_BEQ     = 6'h04;
    localparam logic [5:0] OPC_BNE     = 6'h05;
    localparam logic [5:0] OPC_ADDI    = 6'h08;
    localparam logic [5:0] OPC_ADDIU   = 6'h09;
    localparam logic [5:0] OPC_ORI     = 6'h0d;
    localparam logic [5:0] OPC_LUI     = 6'h0f;
    localparam logic [5:0] OPC_MUL     = 6'h1c;
    localparam logic [5:0] OPC_LB      = 6'h20;
    localparam logic [5:0] OPC_LH      = 6'h21;
    localparam logic [5:0] OPC_LW      = 6'h23;
    localparam logic [5:0] OPC_SB      = 6'h28;
    localparam logic [5:0] OPC_SH      = 6'h29;
    localparam logic [5:0] OPC_SW      = 6'h2b;

    localparam logic [10:0] FN_ADD  = 11'h020;
    localparam logic [10:0] FN_ADDU = 11'h021;
    localparam logic [10:0] FN_SLT  = 11'h02a;
    localparam logic [10:0] FN_CLZ  = 11'h050;
    localparam logic [10:0] FN_CLO  = 11'h051;
    localparam logic [5:0]  FN_SYSCALL = 6'h0c;

    localparam logic [4:0] REG_V0 = 5'd2;
    localparam logic [4:0] REG_A0 = 5'd4;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SYSCALL,
        ST_OVERFLOW,
        ST_BADINSN,
        ST_BADADDR,
        ST_PASTEND
    } t_status;

    typedef enum logic [4:0] {
        OP_NOP, OP_LOADB, OP_START,
        OP_ADDI, OP_ADDIU, OP_ORI, OP_LUI, OP_SYSCALL,
        OP_ADD, OP_ADDU, OP_SLT, OP_CLZ, OP_CLO, OP_MUL,
        OP_BEQ, OP_BNE, OP_LB, OP_LH, OP_LW, OP_SB, OP_SH, OP_SW,
        OP_BAD
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [4:0]  ra;
        logic [4:0]  rb;
        logic [4:0]  rc;     // destination, also read for the old value
        logic [15:0] imm;
        logic [15:0] ld_off;
        logic [7:0]  ld_byte;
    } t_item;

    // queue <-> back handshake
    typedef struct packed {
        logic head_vld;
        logic pop;
    } t_qctl;

    function automatic logic [5:0] lead_zeros(input logic [31:0] v);
        logic [5:0] n;
        n = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) n = 6'(31 - i);
        end
        return n;
    endfunction

    function automatic logic add_ovf(input logic [31:0] a, input logic [31:0] b,
                                     input logic [31:0] r);
        return (~(a[31] ^ b[31])) & (a[31] ^ r[31]);
    endfunction

endpackage

[rtl/meu_ram.sv]
// Generic single-write, single-read RAM with registered read.
module meu_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        if (i_rd_en) r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

[rtl/meu_front.sv]
// Front end: classifies an incoming beat and picks register read ports.
module meu_front (
    input  logic [1:0]     i_command,
    input  logic [31:0]    i_instruction,
    input  logic [15:0]    i_load_offset,
    input  logic [7:0]     i_load_byte,
    output meu_pkg::t_item o_item
);
    import meu_pkg::*;

    logic [5:0]  opc;
    logic [10:0] fn;
    t_item       item;

    assign opc = i_instruction[31:26];
    assign fn  = i_instruction[10:0];

    always_comb begin
        item         = '0;
        item.op      = OP_BAD;
        item.ra      = i_instruction[25:21];
        item.rb      = i_instruction[20:16];
        item.rc      = i_instruction[20:16];
        item.imm     = i_instruction[15:0];
        item.ld_off  = i_load_offset;
        item.ld_byte = i_load_byte;
        case (opc)
            OPC_SPECIAL: begin
                item.rc = i_instruction[15:11];
                if (i_instruction[5:0] == FN_SYSCALL) begin
                    item.op = OP_SYSCALL;
                    item.ra = REG_V0;
                    item.rb = REG_A0;
                end else begin
                    case (fn)
                        FN_ADD:  item.op = OP_ADD;
                        FN_ADDU: item.op = OP_ADDU;
                        FN_SLT:  item.op = OP_SLT;
                        FN_CLZ:  item.op = OP_CLZ;
                        FN_CLO:  item.op = OP_CLO;
                        default: item.op = OP_BAD;
                    endcase
                end
            end
            OPC_MUL: begin
                item.op = OP_MUL;
                item.rc = i_instruction[15:11];
            end
            OPC_ADDI:  item.op = OP_ADDI;
            OPC_ADDIU: item.op = OP_ADDIU;
            OPC_ORI:   item.op = OP_ORI;
            OPC_LUI:   item.op = OP_LUI;
            OPC_BEQ:   item.op = OP_BEQ;
            OPC_BNE:   item.op = OP_BNE;
            OPC_LB:    item.op = OP_LB;
            OPC_LH:    item.op = OP_LH;
            OPC_LW:    item.op = OP_LW;
            OPC_SB:    item.op = OP_SB;
            OPC_SH:    item.op = OP_SH;
            OPC_SW:    item.op = OP_SW;
            default:   item.op = OP_BAD;
        endcase
        case (i_command)
            CMD_EXEC:  ;
            CMD_LOAD:  item.op = OP_LOADB;
            CMD_START: item.op = OP_START;
            default:   item.op = OP_NOP;
        endcase
    end

    assign o_item = item;
endmodule

[rtl/meu_queue.sv]
// Short FIFO between the front end and the execute back end.
module meu_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  meu_pkg::t_item i_item,
    output logic           o_full,
    input  meu_pkg::t_qctl i_ctl,
    output meu_pkg::t_item o_head,
    output logic           o_head_vld
);
    import meu_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_item          r_slot [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           do_pop;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_head_vld = (r_count != '0);
    assign o_head     = r_slot[r_rd_ptr];
    assign do_pop     = i_ctl.pop && o_head_vld;

    always_comb begin
        n_count = r_count;
        if (i_push && !do_pop) n_count = r_count + 1'b1;
        if (!i_push && do_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push)
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            if (do_pop)
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_item;
    end
endmodule

[rtl/meu_back.sv]
// Back end: register read stage, execute stage and result register.
module meu_back #(
    parameter int unsigned DATA_BYTES = meu_pkg::DATA_BYTES_DEF,
    parameter logic [31:0] DATA_BASE  = meu_pkg::DATA_BASE_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [15:0]    i_entry_point,
    input  logic [16:0]    i_program_length,
    input  logic [15:0]    i_data_size,
    input  meu_pkg::t_item i_head,
    input  logic           i_head_vld,
    output meu_pkg::t_qctl o_ctl,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [2:0]     o_status,
    output logic [31:0]    o_next_pc,
    output logic           o_reg_written,
    output logic [4:0]     o_reg_number,
    output logic [31:0]    o_old_value,
    output logic [31:0]    o_new_value,
    output logic [31:0]    o_service_code,
    output logic [31:0]    o_service_arg
);
    import meu_pkg::*;

    localparam int unsigned LANE_DEPTH = DATA_BYTES / 4;
    localparam int unsigned LANE_AW    = (LANE_DEPTH > 1) ? $clog2(LANE_DEPTH) : 1;

    logic adv;

    // register read stage
    logic        r_s1_vld;
    t_item       r_s1;
    logic        r_va, r_vb, r_vc;
    logic        r_byp_we, r_byp_clr;
    logic [4:0]  r_byp_idx;
    logic [31:0] r_byp_val;
    logic [31:0] r_rv;
    logic [31:0] ram_a, ram_b, ram_c;

    // architectural state
    logic [31:0] r_pc;
    t_status     r_fault;

    // result stage
    logic        r_s2_vld;
    t_status     r_s2_status;
    logic [31:0] r_s2_npc;
    logic        r_s2_we;
    logic [4:0]  r_s2_dst;
    logic [31:0] r_s2_old, r_s2_alu, r_s2_svc, r_s2_arg;
    logic        r_s2_clr, r_s2_ld;
    logic [1:0]  r_s2_size;   // 0 byte, 1 half, 2 word
    logic [1:0]  r_s2_lane;
    logic [31:0] s2_newv;
    logic [7:0]  lane_q [4];

    assign adv      = !r_s2_vld || !i_stall;
    assign o_ctl.pop      = adv;
    assign o_ctl.head_vld = i_head_vld;

    function automatic logic [31:0] fwd(input logic [4:0] idx, input logic [31:0] ram,
                                        input logic vld, input logic s2_vld,
                                        input logic s2_clr, input logic s2_we,
                                        input logic [4:0] s2_dst, input logic [31:0] s2_v,
                                        input logic b_clr, input logic b_we,
                                        input logic [4:0] b_idx, input logic [31:0] b_v);
        logic [31:0] r;
        if (s2_vld && s2_clr)                   r = '0;
        else if (s2_vld && s2_we && s2_dst == idx) r = s2_v;
        else if (b_clr)                         r = '0;
        else if (b_we && b_idx == idx)          r = b_v;
        else if (vld)                           r = ram;
        else                                    r = '0;
        return r;
    endfunction

    // register file copies, one per read port
    logic       rf_we;
    assign rf_we = adv && r_s2_vld && r_s2_we;

    meu_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .i_clk(i_clk), .i_wr_en(rf_we), .i_wr_addr(r_s2_dst), .i_wr_data(s2_newv),
        .i_rd_en(adv), .i_rd_addr(i_head.ra), .o_rd_data(ram_a));
    meu_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .i_clk(i_clk), .i_wr_en(rf_we), .i_wr_addr(r_s2_dst), .i_wr_data(s2_newv),
        .i_rd_en(adv), .i_rd_addr(i_head.rb), .o_rd_data(ram_b));
    meu_ram #(.WIDTH(32), .DEPTH(32)) u_rf_c (
        .i_clk(i_clk), .i_wr_en(rf_we), .i_wr_addr(r_s2_dst), .i_wr_data(s2_newv),
        .i_rd_en(adv), .i_rd_addr(i_head.rc), .o_rd_data(ram_c));

    // execute
    logic [31:0] a, b, c, imm_se, sum_ai, sum_ab, addr, ofs;
    logic [16:0] limit;
    logic [32:0] acc_end;
    logic [2:0]  acc_bytes;
    logic        addr_ok;
    t_status     st;
    logic [31:0] npc, newv, svc, arg;
    logic        wr, is_ld, clr;
    logic [1:0]  size;
    logic [3:0]  lane_we;
    logic [7:0]  lane_d [4];
    logic [LANE_AW-1:0] lane_addr;
    logic [31:0] n_pc;
    t_status     n_fault;

    assign a = fwd(r_s1.ra, ram_a, r_va, r_s2_vld, r_s2_clr, r_s2_we, r_s2_dst, s2_newv,
                   r_byp_clr, r_byp_we, r_byp_idx, r_byp_val);
    assign b = fwd(r_s1.rb, ram_b, r_vb, r_s2_vld, r_s2_clr, r_s2_we, r_s2_dst, s2_newv,
                   r_byp_clr, r_byp_we, r_byp_idx, r_byp_val);
    assign c = fwd(r_s1.rc, ram_c, r_vc, r_s2_vld, r_s2_clr, r_s2_we, r_s2_dst, s2_newv,
                   r_byp_clr, r_byp_we, r_byp_idx, r_byp_val);

    assign imm_se = {{16{r_s1.imm[15]}}, r_s1.imm};
    assign sum_ai = a + imm_se;
    assign sum_ab = a + b;
    assign addr   = sum_ai;
    assign ofs    = addr - DATA_BASE;
    assign limit  = ({1'b0, i_data_size} < 17'(DATA_BYTES)) ? {1'b0, i_data_size}
                                                            : 17'(DATA_BYTES);

    always_comb begin
        case (r_s1.op)
            OP_LH, OP_SH: acc_bytes = 3'd2;
            OP_LW, OP_SW: acc_bytes = 3'd4;
            default:      acc_bytes = 3'd1;
        endcase
        acc_end = {1'b0, ofs} + 33'(acc_bytes);
        addr_ok = (addr >= DATA_BASE) && (acc_end <= {16'b0, limit})
                  && ((addr[1:0] & (acc_bytes[1:0] - 2'd1)) == 2'd0);
    end

    always_comb begin
        st        = ST_OK;
        npc       = r_pc;
        wr        = 1'b0;
        newv      = '0;
        svc       = '0;
        arg       = '0;
        is_ld     = 1'b0;
        clr       = 1'b0;
        size      = 2'd0;
        lane_we   = '0;
        lane_addr = ofs[LANE_AW+1:2];
        for (int k = 0; k < 4; k++) lane_d[k] = b[8*k +: 8];
        n_pc      = r_pc;
        n_fault   = r_fault;
        case (r_s1.op)
            OP_START: begin
                npc     = {16'b0, i_entry_point};
                n_pc    = npc;
                n_fault = ST_OK;
                clr     = 1'b1;
            end
            OP_LOADB: begin
                lane_addr = r_s1.ld_off[LANE_AW+1:2];
                for (int k = 0; k < 4; k++) lane_d[k] = r_s1.ld_byte;
                if ({16'b0, r_s1.ld_off} < 32'(DATA_BYTES))
                    lane_we[r_s1.ld_off[1:0]] = 1'b1;
            end
            OP_NOP: ;
            default: begin
                if (r_fault != ST_OK) begin
                    st = r_fault;
                end else if (r_pc >= {15'b0, i_program_length}) begin
                    st = ST_PASTEND;
                end else begin
                    npc = r_pc + 32'd1;
                    case (r_s1.op)
                        OP_ADDI: begin
                            if (add_ovf(a, imm_se, sum_ai)) st = ST_OVERFLOW;
                            else begin wr = 1'b1; newv = sum_ai; end
                        end
                        OP_ADDIU: begin wr = 1'b1; newv = sum_ai; end
                        OP_ORI:   begin wr = 1'b1; newv = a | {16'b0, r_s1.imm}; end
                        OP_LUI:   begin wr = 1'b1; newv = {r_s1.imm, 16'b0}; end
                        OP_SYSCALL: begin
                            st  = ST_SYSCALL;
                            svc = a;
                            arg = b;
                        end
                        OP_ADD: begin
                            if (add_ovf(a, b, sum_ab)) st = ST_OVERFLOW;
                            else begin wr = 1'b1; newv = sum_ab; end
                        end
                        OP_ADDU: begin wr = 1'b1; newv = sum_ab; end
                        OP_SLT: begin
                            wr = 1'b1;
                            newv = {31'b0, ($signed(a) < $signed(b))};
                        end
                        OP_CLZ: begin wr = 1'b1; newv = {26'b0, lead_zeros(a)}; end
                        OP_CLO: begin wr = 1'b1; newv = {26'b0, lead_zeros(~a)}; end
                        OP_MUL: begin wr = 1'b1; newv = a * b; end
                        OP_BEQ, OP_BNE: begin
                            if ((a == b) == (r_s1.op == OP_BEQ)) npc = r_pc + imm_se;
                        end
                        OP_LB, OP_LH, OP_LW, OP_SB, OP_SH, OP_SW: begin
                            size = (acc_bytes == 3'd4) ? 2'd2 : {1'b0, acc_bytes[1]};
                            if (!addr_ok) begin
                                st = ST_BADADDR;
                            end else if (r_s1.op == OP_SB) begin
                                for (int k = 0; k < 4; k++) lane_d[k] = b[7:0];
                                lane_we[ofs[1:0]] = 1'b1;
                            end else if (r_s1.op == OP_SH) begin
                                for (int k = 0; k < 4; k++) lane_d[k] = b[8*(k%2) +: 8];
                                lane_we = ofs[1] ? 4'b1100 : 4'b0011;
                            end else if (r_s1.op == OP_SW) begin
                                lane_we = 4'b1111;
                            end else begin
                                is_ld = 1'b1;
                                wr    = 1'b1;
                            end
                        end
                        default: st = ST_BADINSN;
                    endcase
                end
                if (st == ST_OVERFLOW || st == ST_BADINSN || st == ST_BADADDR
                    || st == ST_PASTEND) begin
                    wr      = 1'b0;
                    is_ld   = 1'b0;
                    npc     = r_pc;
                    n_fault = st;
                end
                n_pc = npc;
            end
        endcase
        if (r_s1.rc == 5'd0) begin
            wr    = 1'b0;
            is_ld = 1'b0;
        end
    end

    // data store: four byte lanes
    for (genvar k = 0; k < 4; k++) begin : g_lane
        meu_ram #(.WIDTH(8), .DEPTH(LANE_DEPTH)) u_lane (
            .i_clk(i_clk), .i_wr_en(adv && r_s1_vld && lane_we[k]),
            .i_wr_addr(lane_addr), .i_wr_data(lane_d[k]),
            .i_rd_en(adv), .i_rd_addr(lane_addr), .o_rd_data(lane_q[k]));
    end

    always_comb begin
        case (r_s2_size)
            2'd0:    s2_newv = {{24{lane_q[r_s2_lane][7]}}, lane_q[r_s2_lane]};
            2'd1:    s2_newv = r_s2_lane[1]
                               ? {{16{lane_q[3][7]}}, lane_q[3], lane_q[2]}
                               : {{16{lane_q[1][7]}}, lane_q[1], lane_q[0]};
            default: s2_newv = {lane_q[3], lane_q[2], lane_q[1], lane_q[0]};
        endcase
        if (!r_s2_ld) s2_newv = r_s2_alu;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_byp_we  <= 1'b0;
            r_byp_clr <= 1'b0;
            r_rv      <= '0;
            r_pc      <= '0;
            r_fault   <= ST_OK;
        end else if (adv) begin
            r_s1_vld  <= i_head_vld;
            r_s2_vld  <= r_s1_vld;
            r_byp_we  <= r_s2_vld && r_s2_we;
            r_byp_clr <= r_s2_vld && r_s2_clr;
            if (r_s2_vld && r_s2_clr)     r_rv <= '0;
            else if (r_s2_vld && r_s2_we) r_rv[r_s2_dst] <= 1'b1;
            if (r_s1_vld) begin
                r_pc    <= n_pc;
                r_fault <= n_fault;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1        <= i_head;
            r_va        <= r_rv[i_head.ra];
            r_vb        <= r_rv[i_head.rb];
            r_vc        <= r_rv[i_head.rc];
            r_byp_idx   <= r_s2_dst;
            r_byp_val   <= s2_newv;
            r_s2_status <= st;
            r_s2_npc    <= npc;
            r_s2_we     <= wr;
            r_s2_dst    <= wr ? r_s1.rc : 5'd0;
            r_s2_old    <= wr ? c : 32'd0;
            r_s2_alu    <= wr ? newv : 32'd0;
            r_s2_svc    <= svc;
            r_s2_arg    <= arg;
            r_s2_clr    <= clr;
            r_s2_ld     <= is_ld;
            r_s2_size   <= size;
            r_s2_lane   <= ofs[1:0];
        end
    end

    assign o_valid        = r_s2_vld;
    assign o_status       = r_s2_status;
    assign o_next_pc      = r_s2_npc;
    assign o_reg_written  = r_s2_we;
    assign o_reg_number   = r_s2_dst;
    assign o_old_value    = r_s2_old;
    assign o_new_value    = r_s2_we ? s2_newv : 32'd0;
    assign o_service_code = r_s2_svc;
    assign o_service_arg  = r_s2_arg;
endmodule

[rtl/mips_subset_execute_unit_top.sv]
// Top level of the MIPS32 subset execute unit.
// One beat in, one result beat out, sustained at one beat per clock while
// i_stall is low. A beat is decoded in the front end, waits in a two-entry
// queue, reads the register file (three copies with registered reads) in
// the next stage, executes and updates pc, fault state and the data store,
// and its result sits in the output register, where load data and the
// register write are completed. Results from the output stage and the
// previous write are forwarded into the execute stage, so back-to-back
// dependent instructions, loads included, run without bubbles.
module mips_subset_execute_unit_top #(
    parameter int unsigned DATA_BYTES = meu_pkg::DATA_BYTES_DEF,
    parameter logic [31:0] DATA_BASE  = meu_pkg::DATA_BASE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [meu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [meu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_command,
    input  logic [31:0]                     i_instruction,
    input  logic [15:0]                     i_load_offset,
    input  logic [7:0]                      i_load_byte,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [2:0]                      o_status,
    output logic [31:0]                     o_next_pc,
    output logic                            o_reg_written,
    output logic [4:0]                      o_reg_number,
    output logic [31:0]                     o_old_value,
    output logic [31:0]                     o_new_value,
    output logic [31:0]                     o_service_code,
    output logic [31:0]                     o_service_arg
);
    import meu_pkg::*;

    logic [15:0] r_entry;
    logic [16:0] r_plen;
    logic [15:0] r_dsize;
    t_item       dec_item, head;
    logic        full, head_vld;
    t_qctl       qctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
            r_plen  <= '0;
            r_dsize <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ENTRY:  r_entry <= i_cfg_data[15:0];
                CFG_LENGTH: r_plen  <= i_cfg_data[16:0];
                CFG_DSIZE:  r_dsize <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    meu_front u_front (
        .i_command(i_command), .i_instruction(i_instruction),
        .i_load_offset(i_load_offset), .i_load_byte(i_load_byte),
        .o_item(dec_item));

    meu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_valid && !full), .i_item(dec_item), .o_full(full),
        .i_ctl(qctl), .o_head(head), .o_head_vld(head_vld));

    assign o_stall = full;

    meu_back #(.DATA_BYTES(DATA_BYTES), .DATA_BASE(DATA_BASE)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_entry_point(r_entry), .i_program_length(r_plen), .i_data_size(r_dsize),
        .i_head(head), .i_head_vld(head_vld), .o_ctl(qctl),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_next_pc(o_next_pc), .o_reg_written(o_reg_written),
        .o_reg_number(o_reg_number), .o_old_value(o_old_value),
        .o_new_value(o_new_value), .o_service_code(o_service_code),
        .o_service_arg(o_service_arg));

`ifndef NO_ASSERTIONS
    a_no_zero_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_reg_written && o_reg_number == 5'd0))
        else $error("write to register zero reported");
    a_fault_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_OVERFLOW || o_status == ST_BADINSN
                     || o_status == ST_BADADDR || o_status == ST_PASTEND))
        |-> !o_reg_written)
        else $error("faulting beat wrote a register");
    a_syscall_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_SYSCALL) |-> !o_reg_written)
        else $error("syscall wrote a register");
`endif
endmodule
